// File: src/sliding_window_median_cost_defines.svh
// ----------------------------------------------------------------------------
// Sliding window median cost: assertion macros
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_COST_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_COST_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define SWMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SWMC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: src/swmc_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window median cost package
// Fixed widths, register map and the control word of the sorted cell row.
// ----------------------------------------------------------------------------
package swmc_pkg;

    localparam int COST_BITS = 37;
    localparam int WS_BITS   = 6;
    localparam int ADDR_BITS = 3;

    // Register index, taken from paddr[2].
    localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;
    localparam logic [WS_BITS-1:0] WINDOW_SIZE_RESET = 6'd3;

    typedef struct packed {
        logic upd;     // apply the remove/insert step this cycle
        logic rem_en;  // window is full: drop the oldest sample first
    } cell_ctrl_t;

endpackage

// File: src/swmc_if.sv
// ----------------------------------------------------------------------------
// Sliding window median cost channels
// Valid/ready channels for the incoming samples and the outgoing costs.
// ----------------------------------------------------------------------------
interface swmc_sample_if #(
    parameter int SAMPLE_BITS = 32
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink (input valid, input sample, input restart, output ready);
endinterface

interface swmc_cost_if
    import swmc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [COST_BITS-1:0] cost;

    modport source (output valid, output cost, input ready);
    modport sink (input valid, input cost, output ready);
endinterface

// File: src/swmc_cell.sv
// ----------------------------------------------------------------------------
// Sorted row cell
// Holds one sorted sample, takes part in the remove/insert step with its
// neighbors and adds its absolute deviation to the passing partial sum.
// ----------------------------------------------------------------------------
module swmc_cell
    import swmc_pkg::*;
#(
    parameter int IDX         = 0,
    parameter int SAMPLE_BITS = 32,
    parameter int CW          = 6
) (
    input  logic                   clk,
    input  cell_ctrl_t             ctrl,
    input  logic [SAMPLE_BITS-1:0] v,
    input  logic [SAMPLE_BITS-1:0] old,
    input  logic [CW-1:0]          m,
    input  logic [CW-1:0]          k,
    input  logic [CW-1:0]          n,
    input  logic [SAMPLE_BITS-1:0] med,
    input  logic [SAMPLE_BITS-1:0] prev_t,
    input  logic                   prev_gt,
    input  logic                   prev_rm,
    input  logic [SAMPLE_BITS-1:0] next_s,
    input  logic [COST_BITS-1:0]   sum_in,
    output logic [SAMPLE_BITS-1:0] s,
    output logic [SAMPLE_BITS-1:0] t,
    output logic                   gt,
    output logic                   rm,
    output logic [COST_BITS-1:0]   sum_out
);

    logic [SAMPLE_BITS-1:0] val_reg;
    logic [SAMPLE_BITS-1:0] val_next;
    logic [COST_BITS-1:0]   sum_reg;
    logic [COST_BITS-1:0]   sum_next;
    logic [SAMPLE_BITS-1:0] diff;
    logic                   eq;

    assign s = val_reg;

    // The removed slot is the first copy of the old sample, or the top entry
    // when no copy is found. Every cell from there on takes its upper neighbor.
    assign eq = (val_reg == old) && (CW'(IDX) < m);
    assign rm = prev_rm || (ctrl.rem_en && (eq || ({1'b0, m} <= (CW + 1)'(IDX + 1))));
    assign t  = rm ? next_s : val_reg;
    assign gt = (CW'(IDX) >= k) || (t > v);

    always_comb
    begin
        if (!gt)
        begin
            val_next = t;
        end
        else if (!prev_gt)
        begin
            val_next = v;
        end
        else
        begin
            val_next = prev_t;
        end
    end

    assign diff     = (val_reg >= med) ? (val_reg - med) : (med - val_reg);
    assign sum_next = (CW'(IDX) < n) ? (sum_in + COST_BITS'(diff)) : sum_in;
    assign sum_out  = sum_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.upd)
        begin
            val_reg <= val_next;
        end
        sum_reg <= sum_next;
    end

endmodule

// File: src/swmc_age_ring.sv
// ----------------------------------------------------------------------------
// Arrival order ring
// Samples in arrival order; one slot is read and rewritten per transfer.
// ----------------------------------------------------------------------------
module swmc_age_ring #(
    parameter int DEPTH       = 32,
    parameter int SAMPLE_BITS = 32,
    parameter int SW          = 5
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [SW-1:0]          addr,
    input  logic [SAMPLE_BITS-1:0] wdata,
    output logic [SAMPLE_BITS-1:0] rdata
);

    logic [SAMPLE_BITS-1:0] age_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] rdata_reg;

    assign rdata = rdata_reg;

    // Read returns the sample being replaced.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg     <= age_mem[addr];
            age_mem[addr] <= wdata;
        end
    end

endmodule

// File: src/sliding_window_median_cost.sv
// ----------------------------------------------------------------------------
// Sliding window median cost
// Sum of absolute deviations from the lower median over a sliding window,
// kept in a sorted row of cells next to an arrival order ring.
//
//   Channel   Dir   Kind          Payload
//   samples   in    valid/ready   sample, restart
//   results   out   valid/ready   cost
//   config    in    APB           window_size at byte address 0
//
// A sample that leaves the window short of full passes through S_UPDATE only.
// A sample that produces a cost goes on through S_MEDIAN, S_SUM and S_DONE,
// while the partial sum ripples through the cell row one cell per cycle.
// The cost waits in an output register, so the next sample is taken while
// the result is stalled; a new cost waits only if that register is full.
// Reset empties the window and sets window_size to 3; no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_median_cost
    import swmc_pkg::*;
#(
    parameter int WINDOW_MAX  = 32,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    swmc_sample_if.sink           samples,
    swmc_cost_if.source           results,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int NW = (CW > WS_BITS) ? CW : WS_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_MEDIAN,
        S_SUM,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [WS_BITS-1:0]     window_size_reg;
    logic [CW-1:0]          fill_reg;
    logic [SW-1:0]          slot_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   out_valid_reg;
    logic [COST_BITS-1:0]   cost_reg;
    logic [SAMPLE_BITS-1:0] v_reg;
    logic [CW-1:0]          m_reg;
    logic [CW-1:0]          n_reg;
    logic                   rem_reg;
    logic                   due_reg;
    logic [SAMPLE_BITS-1:0] med_reg;

    logic [NW-1:0]          ws_ext;
    logic [CW-1:0]          n_eff;
    logic [CW-1:0]          fc0;
    logic [CW-1:0]          fc1;
    logic [SW-1:0]          sl0;
    logic [SW-1:0]          sl1;
    logic [SW-1:0]          sl2;
    logic [CW-1:0]          sl_p1;
    logic                   full;
    logic [CW-1:0]          fill_next;
    logic [SW-1:0]          slot_next;
    logic                   accept;
    logic                   cfg_we;
    logic                   out_free;

    logic [SAMPLE_BITS-1:0] old_sample;
    logic [CW-1:0]          k_cnt;
    logic [CW-1:0]          mid;
    logic [SAMPLE_BITS-1:0] med_sel;
    cell_ctrl_t             ctrl;

    logic [SAMPLE_BITS-1:0] cell_s   [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] cell_t   [WINDOW_MAX];
    logic                   cell_gt  [WINDOW_MAX];
    logic                   cell_rm  [WINDOW_MAX];
    logic [COST_BITS-1:0]   cell_sum [WINDOW_MAX];

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2:2] == REG_WINDOW_SIZE);
    assign prdata = (paddr[2:2] == REG_WINDOW_SIZE) ? {{(32 - WS_BITS){1'b0}}, window_size_reg}
                                                   : 32'd0;

    // Effective window size: zero counts as one, large values saturate.
    assign ws_ext = NW'(window_size_reg);
    always_comb
    begin
        if (ws_ext == '0)
        begin
            n_eff = CW'(1);
        end
        else if (ws_ext > NW'(WINDOW_MAX))
        begin
            n_eff = CW'(WINDOW_MAX);
        end
        else
        begin
            n_eff = CW'(ws_ext);
        end
    end

    // Window bookkeeping for the sample on the input channel.
    always_comb
    begin
        fc0 = samples.restart ? '0 : fill_reg;
        sl0 = samples.restart ? '0 : slot_reg;
        sl1 = (CW'(sl0) >= n_eff) ? '0 : sl0;
        if (fc0 > n_eff)
        begin
            fc1 = '0;
            sl2 = '0;
        end
        else
        begin
            fc1 = fc0;
            sl2 = sl1;
        end
        full      = (fc1 == n_eff);
        fill_next = full ? fc1 : (fc1 + CW'(1));
        sl_p1     = CW'(sl2) + CW'(1);
        slot_next = (sl_p1 >= n_eff) ? '0 : SW'(sl_p1);
    end

    assign samples.ready = (state_reg == S_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign out_free      = !out_valid_reg || results.ready;
    assign results.valid = out_valid_reg;
    assign results.cost  = cost_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            window_size_reg <= WINDOW_SIZE_RESET;
            fill_reg        <= '0;
            slot_reg        <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            cost_reg        <= '0;
        end
        else
        begin
            // A finished cost enters the output register once it is free.
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
                cost_reg      <= cell_sum[WINDOW_MAX-1];
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                window_size_reg <= pwdata[WS_BITS-1:0];
                fill_reg        <= '0;
                slot_reg        <= '0;
            end
            else if (accept)
            begin
                fill_reg <= fill_next;
                slot_reg <= slot_next;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    state_reg <= due_reg ? S_MEDIAN : S_IDLE;
                end
                S_MEDIAN:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(WINDOW_MAX - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v_reg   <= samples.sample;
            m_reg   <= fc1;
            n_reg   <= n_eff;
            rem_reg <= full;
            due_reg <= (fill_next == n_eff);
        end
        if (state_reg == S_MEDIAN)
        begin
            med_reg <= med_sel;
        end
    end

    swmc_age_ring #(
        .DEPTH       (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SW          (SW)
    ) u_ring (
        .clk   (clk),
        .en    (accept),
        .addr  (sl2),
        .wdata (samples.sample),
        .rdata (old_sample)
    );

    assign ctrl.upd    = (state_reg == S_UPDATE);
    assign ctrl.rem_en = rem_reg;
    assign k_cnt       = rem_reg ? (m_reg - CW'(1)) : m_reg;
    assign mid         = (n_reg - CW'(1)) >> 1;

    always_comb
    begin
        med_sel = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            if (mid == CW'(i))
            begin
                med_sel = med_sel | cell_s[i];
            end
        end
    end

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        logic [SAMPLE_BITS-1:0] prev_t;
        logic                   prev_gt;
        logic                   prev_rm;
        logic [SAMPLE_BITS-1:0] next_s;
        logic [COST_BITS-1:0]   sum_in;

        if (i == 0)
        begin : g_first
            assign prev_t  = '0;
            assign prev_gt = 1'b0;
            assign prev_rm = 1'b0;
            assign sum_in  = '0;
        end
        else
        begin : g_inner
            assign prev_t  = cell_t[i-1];
            assign prev_gt = cell_gt[i-1];
            assign prev_rm = cell_rm[i-1];
            assign sum_in  = cell_sum[i-1];
        end

        if (i == WINDOW_MAX - 1)
        begin : g_last
            assign next_s = '0;
        end
        else
        begin : g_below
            assign next_s = cell_s[i+1];
        end

        swmc_cell #(
            .IDX         (i),
            .SAMPLE_BITS (SAMPLE_BITS),
            .CW          (CW)
        ) u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .v       (v_reg),
            .old     (old_sample),
            .m       (m_reg),
            .k       (k_cnt),
            .n       (n_reg),
            .med     (med_reg),
            .prev_t  (prev_t),
            .prev_gt (prev_gt),
            .prev_rm (prev_rm),
            .next_s  (next_s),
            .sum_in  (sum_in),
            .s       (cell_s[i]),
            .t       (cell_t[i]),
            .gt      (cell_gt[i]),
            .rm      (cell_rm[i]),
            .sum_out (cell_sum[i])
        );
    end

endmodule

// File: src/swmc_checker.sv
// ----------------------------------------------------------------------------
// Sliding window median cost port checker
// Watches the channel ports of the top level over time.
// ----------------------------------------------------------------------------
`include "sliding_window_median_cost_defines.svh"

module swmc_checker
    import swmc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [COST_BITS-1:0] out_cost
);

    // A stalled cost stays offered and unchanged.
    `SWMC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_cost), "stalled cost changed or dropped")

    // Samples are worked one at a time: a transfer closes the input.
    `SWMC_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "input still open after a transfer")

    // A new cost is only offered as the block finishes an item.
    `SWMC_ASSERT_SAME(a_cost_at_finish, clk, rst_n, $rose(out_valid), !$past(in_ready), "cost offered while the block was idle")

endmodule

bind sliding_window_median_cost swmc_checker u_swmc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_cost  (results.cost)
);
